### rtl/core/smpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg: shared types for the sorted minimum-first priority queue
// Holds the operation codes, the status codes and the control beat that is
// broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
package smpq_pkg;

	localparam int unsigned DataWidth  = 32;
	localparam int unsigned CountWidth = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic signed [DataWidth-1:0] data_t;

	// Control broadcast to all cells together
	typedef struct packed {
		logic  insert_en;
		logic  remove_en;
		data_t value;
	} cell_ctl_t;

endpackage
`default_nettype wire

### rtl/core/smpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted chain
// Holds one entry. On insert it either keeps its entry, takes its left
// neighbour's entry or takes the new value; on remove it takes its right
// neighbour's entry. It tells its right neighbour whether it shifts.
// ----------------------------------------------------------------------------
module smpq_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 5
) (
	input  wire                    clk,
	input  smpq_pkg::cell_ctl_t    ctl,
	input  wire  [CW-1:0]          fill,
	input  smpq_pkg::data_t        left_entry,
	input  wire                    left_shift,
	input  smpq_pkg::data_t        right_entry,
	output smpq_pkg::data_t        entry,
	output logic                   shift
);

	smpq_pkg::data_t entry_q;

	// Flag the slot as part of the shifted region: empty, or holding a larger value
	always_comb begin
		shift = (CW'(IDX) >= fill) || (entry_q > ctl.value);
	end

	// Advance the entry
	always_ff @(posedge clk) begin
		if (ctl.insert_en && shift) begin
			entry_q <= left_shift ? left_entry : ctl.value;
		end else if (ctl.remove_en) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

### rtl/core/sorted_min_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_min_priority_queue: minimum-first queue kept in a sorted cell chain
// The result beat appears on done in the cycle after start is taken.
// Throughput: one insert or remove per cycle; busy stays low, every cell
// compares against the broadcast value in parallel and shifts in one step.
// Reset clears the count and the result strobe; entries stay undefined
// until written. The receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire                 op,
	input  wire signed [31:0]   value,
	output logic                done,
	output logic signed [31:0]  removed_value,
	output logic [1:0]          status,
	output logic signed [31:0]  min_value,
	output logic signed [31:0]  max_value,
	output logic [4:0]          count
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	smpq_pkg::cell_ctl_t ctl;
	smpq_pkg::data_t     entry_chain [DEPTH+1];
	logic                shift_chain [DEPTH+1];

	logic [CW-1:0]       count_q;
	smpq_pkg::data_t     max_q;
	smpq_pkg::data_t     removed_q;
	smpq_pkg::status_t   status_q;
	logic                done_q;

	logic                accept;
	logic                full;
	logic                empty;
	logic [CW+4:0]       count_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	// Broadcast the control beat to the chain
	always_comb begin
		ctl.insert_en = accept && (op == smpq_pkg::OP_INSERT) && !full;
		ctl.remove_en = accept && (op == smpq_pkg::OP_REMOVE) && !empty;
		ctl.value     = value;
	end

	assign entry_chain[0] = '0;
	assign shift_chain[0] = 1'b0;

	// Build the row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		smpq_pkg::data_t right;
		if (i == DEPTH - 1) begin : g_last
			assign right = entry_chain[i+1];
		end else begin : g_mid
			assign right = entry_chain[i+2];
		end
		smpq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.fill        (count_q),
			.left_entry  (entry_chain[i]),
			.left_shift  (shift_chain[i]),
			.right_entry (right),
			.entry       (entry_chain[i+1]),
			.shift       (shift_chain[i+1])
		);
	end

	// Track the count and the largest value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.insert_en) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.remove_en) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert_en && (empty || (value >= max_q))) begin
			max_q <= value;
		end
	end

	// Capture the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q <= ctl.remove_en ? entry_chain[1] : '0;
			if (op == smpq_pkg::OP_INSERT) begin
				status_q <= full ? smpq_pkg::ST_FULL : smpq_pkg::ST_OK;
			end else begin
				status_q <= empty ? smpq_pkg::ST_EMPTY : smpq_pkg::ST_OK;
			end
		end
	end

	// Drive the result ports; an empty store reports zero bounds
	assign count_ext     = {5'b0, count_q};
	assign done          = done_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign min_value     = empty ? 32'sd0 : entry_chain[1];
	assign max_value     = empty ? 32'sd0 : max_q;
	assign count         = count_ext[4:0];

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count exceeds depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done_q)
		else $error("result beat missing after accept");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == smpq_pkg::ST_FULL)) |-> full)
		else $error("full status with room left");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == smpq_pkg::ST_EMPTY)) |-> empty && (removed_q == '0))
		else $error("empty status with stored entries");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count moved without a beat");

endmodule
`default_nettype wire
